// ----- design/mcs_pkg.sv -----
// package for the message content screen: item types, verdict codes,
// register indexes and hash constants. no dependencies.
package mcs_pkg;

    localparam int LENGTH_WIDTH_DEF = 16;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_MESSAGE_BYTES      = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BYTE_RUN           = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_MESSAGE_THRESHOLD = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_DISTINCT_RATIO_Q16 = 4'd3;

    localparam logic [15:0] RST_MAX_MESSAGE_BYTES      = 16'd512;
    localparam logic [15:0] RST_MAX_BYTE_RUN           = 16'd8;
    localparam logic [15:0] RST_LONG_MESSAGE_THRESHOLD = 16'd32;
    localparam logic [16:0] RST_MIN_DISTINCT_RATIO_Q16 = 17'd13107;

    // fnv-1a 64 offset basis; the prime is 2^40 + 2^8 + 0xb3
    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

    localparam logic [1:0] VERDICT_NONE      = 2'd0;
    localparam logic [1:0] VERDICT_TOO_LONG  = 2'd1;
    localparam logic [1:0] VERDICT_REPEATED  = 2'd2;
    localparam logic [1:0] VERDICT_LOW_VARIETY = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [63:0] message_hash;
    } out_item_t;

endpackage

// ----- design/message_content_screen.sv -----
// message content screen top level: byte statistics, fnv-1a 64 hash and verdict
// uses mcs_pkg for item types, register indexes, verdict codes and constants
//
//  channel | ports                          | moves
//  --------+--------------------------------+-------------------------------
//  input   | s_valid s_ready s_item         | one message byte and last flag
//  result  | m_valid m_ready m_item         | verdict and hash per message
//  config  | cfg_valid cfg_ready cfg_index  | register write, cfg_data
//
// one byte is taken every cycle while s_ready is high; the hash update is a
// shift-add of the sparse prime in the same cycle as the statistics update.
// a message result passes the judge register, then the output register after
// its last byte; the 17 x LENGTH_WIDTH ratio product sits between the two.
// reset (aresetn low, synchronous) clears all message state, the seen map
// included, and loads register defaults; the seen map is also cleared at once
// on every last byte. a stalled result holds the judge stage, and s_ready
// drops only while both the judge and output registers are full.
module message_content_screen #(
    parameter int LENGTH_WIDTH = mcs_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  mcs_pkg::in_item_t                  s_item,
    output logic                               m_valid,
    input  logic                               m_ready,
    output mcs_pkg::out_item_t                 m_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mcs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int LW     = LENGTH_WIDTH;
    localparam int CMP_W  = (LW > 16) ? LW : 16;
    localparam int PROD_W = 17 + LW;
    localparam logic [LW-1:0] COUNT_MAX = {LW{1'b1}};

    // configuration registers
    logic [15:0] max_bytes_reg;
    logic [15:0] max_run_reg;
    logic [15:0] long_thr_reg;
    logic [16:0] min_ratio_reg;

    // message state
    logic [63:0]    hash_reg;
    logic [LW-1:0]  count_reg;
    logic [LW-1:0]  run_reg;
    logic [LW-1:0]  longest_reg;
    logic [7:0]     prev_reg;
    logic [255:0]   seen_reg;
    logic [8:0]     distinct_reg;

    logic [63:0]    hash_next;
    logic [LW-1:0]  count_next;
    logic [LW-1:0]  run_next;
    logic [LW-1:0]  longest_next;
    logic [7:0]     prev_next;
    logic [8:0]     distinct_next;
    logic [63:0]    hash_x;

    // judge stage
    logic           judge_valid_reg;
    logic [63:0]    judge_hash_reg;
    logic [LW-1:0]  judge_count_reg;
    logic [LW-1:0]  judge_longest_reg;
    logic [8:0]     judge_distinct_reg;

    // output register
    logic               out_valid_reg;
    mcs_pkg::out_item_t out_item_reg;

    logic in_fire;
    logic out_free;
    logic judge_free;
    logic byte_seen;
    logic same_run;

    logic [CMP_W-1:0]  count_ext;
    logic [CMP_W-1:0]  longest_ext;
    logic [PROD_W-1:0] ratio_prod;
    logic [PROD_W-1:0] distinct_scaled;
    logic [1:0]        verdict;

    assign out_free   = !out_valid_reg || m_ready;
    assign judge_free = !judge_valid_reg || out_free;
    assign s_ready    = judge_free;
    assign in_fire    = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign m_valid    = out_valid_reg;
    assign m_item     = out_item_reg;

    // statistics update for the byte on the input
    always_comb begin
        hash_x    = hash_reg ^ {56'd0, s_item.data_byte};
        // x * prime = x<<40 + x<<8 + x*0xb3 (0xb3 = 128+32+16+2+1)
        hash_next = (hash_x << 40) + (hash_x << 8) + (hash_x << 7) + (hash_x << 5)
                  + (hash_x << 4) + (hash_x << 1) + hash_x;

        count_next = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;

        // a zero run means no previous byte yet
        same_run = (run_reg != '0) && (s_item.data_byte == prev_reg);
        if (same_run) begin
            run_next  = (run_reg == COUNT_MAX) ? COUNT_MAX : run_reg + 1'b1;
            prev_next = prev_reg;
        end else begin
            run_next  = {{(LW-1){1'b0}}, 1'b1};
            prev_next = s_item.data_byte;
        end
        longest_next = (run_next > longest_reg) ? run_next : longest_reg;

        byte_seen     = seen_reg[s_item.data_byte];
        distinct_next = byte_seen ? distinct_reg : distinct_reg + 9'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg     <= mcs_pkg::FNV_BASIS;
            count_reg    <= '0;
            run_reg      <= '0;
            longest_reg  <= '0;
            prev_reg     <= '0;
            seen_reg     <= '0;
            distinct_reg <= '0;
        end else if (in_fire) begin
            if (s_item.last_byte) begin
                hash_reg     <= mcs_pkg::FNV_BASIS;
                count_reg    <= '0;
                run_reg      <= '0;
                longest_reg  <= '0;
                prev_reg     <= '0;
                seen_reg     <= '0;
                distinct_reg <= '0;
            end else begin
                hash_reg     <= hash_next;
                count_reg    <= count_next;
                run_reg      <= run_next;
                longest_reg  <= longest_next;
                prev_reg     <= prev_next;
                seen_reg[s_item.data_byte] <= 1'b1;
                distinct_reg <= distinct_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= mcs_pkg::RST_MAX_MESSAGE_BYTES;
            max_run_reg   <= mcs_pkg::RST_MAX_BYTE_RUN;
            long_thr_reg  <= mcs_pkg::RST_LONG_MESSAGE_THRESHOLD;
            min_ratio_reg <= mcs_pkg::RST_MIN_DISTINCT_RATIO_Q16;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mcs_pkg::CFG_MAX_MESSAGE_BYTES:      max_bytes_reg <= cfg_data[15:0];
                mcs_pkg::CFG_MAX_BYTE_RUN:           max_run_reg   <= cfg_data[15:0];
                mcs_pkg::CFG_LONG_MESSAGE_THRESHOLD: long_thr_reg  <= cfg_data[15:0];
                mcs_pkg::CFG_MIN_DISTINCT_RATIO_Q16: min_ratio_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // judge stage holds the final statistics of a message
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            judge_valid_reg <= 1'b0;
        end else if (judge_free) begin
            judge_valid_reg <= in_fire && s_item.last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && s_item.last_byte) begin
            judge_hash_reg     <= hash_next;
            judge_count_reg    <= count_next;
            judge_longest_reg  <= longest_next;
            judge_distinct_reg <= distinct_next;
        end
    end

    // verdict in priority order: too long, repeated, low variety
    always_comb begin
        count_ext       = CMP_W'(judge_count_reg);
        longest_ext     = CMP_W'(judge_longest_reg);
        ratio_prod      = PROD_W'(min_ratio_reg) * PROD_W'(judge_count_reg);
        distinct_scaled = PROD_W'({judge_distinct_reg, 16'd0});
        priority if (count_ext > CMP_W'(max_bytes_reg)) begin
            verdict = mcs_pkg::VERDICT_TOO_LONG;
        end else if (longest_ext >= CMP_W'(max_run_reg)) begin
            verdict = mcs_pkg::VERDICT_REPEATED;
        end else if (count_ext >= CMP_W'(long_thr_reg) && distinct_scaled < ratio_prod) begin
            verdict = mcs_pkg::VERDICT_LOW_VARIETY;
        end else begin
            verdict = mcs_pkg::VERDICT_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= judge_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && judge_valid_reg) begin
            out_item_reg.verdict      <= verdict;
            out_item_reg.message_hash <= judge_hash_reg;
        end
    end

endmodule
